/* hw/rtl/llcc_pkg.sv */
// ----------------------------------------------------------------------------
// llcc_pkg
// Shared constants and tables for the longitude/latitude to cube cell unit.
// ----------------------------------------------------------------------------
package llcc_pkg;

   localparam int MAX_LEVEL     = 30;
   localparam int CORDIC_STAGES = 32;
   localparam int TABLE_LEN     = 40;
   localparam int LEVEL_W       = 5;

   localparam logic signed [35:0] CORDIC_START = 36'sh026DD3B6A;
   localparam logic signed [35:0] Q30_ONE      = 36'sh040000000;
   localparam logic signed [35:0] HALF_TURN    = 36'sh080000000;

   typedef logic signed [35:0] cword_type;

   function automatic cword_type turn_angle(input int idx);
      cword_type r;
      r = '0;
      case (idx)
         0: r = 36'sh020000000;
         1: r = 36'sh012E4051E;
         2: r = 36'sh009FB385B;
         3: r = 36'sh0051111D4;
         4: r = 36'sh0028B0D43;
         5: r = 36'sh00145D7E1;
         6: r = 36'sh000A2F61E;
         7: r = 36'sh000517C55;
         8: r = 36'sh00028BE53;
         9: r = 36'sh000145F2F;
         10: r = 36'sh0000A2F98;
         11: r = 36'sh0000517CC;
         12: r = 36'sh000028BE6;
         13: r = 36'sh0000145F3;
         14: r = 36'sh00000A2FA;
         15: r = 36'sh00000517D;
         16: r = 36'sh0000028BE;
         17: r = 36'sh00000145F;
         18: r = 36'sh000000A30;
         19: r = 36'sh000000518;
         20: r = 36'sh00000028C;
         21: r = 36'sh000000146;
         22: r = 36'sh0000000A3;
         23: r = 36'sh000000051;
         24: r = 36'sh000000029;
         25: r = 36'sh000000014;
         26: r = 36'sh00000000A;
         27: r = 36'sh000000005;
         28: r = 36'sh000000003;
         29: r = 36'sh000000001;
         30: r = 36'sh000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/llcc_cordic.sv */
// ----------------------------------------------------------------------------
// llcc_cordic
// Pipelined rotation-mode CORDIC, one stage per register, producing cosine
// and sine of two angles side by side with a sideband word carried along.
// ----------------------------------------------------------------------------
module llcc_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic signed [31:0]       lng,
   input  logic signed [31:0]       lat,
   input  logic [4:0]               level,
   output logic                     out_valid,
   output llcc_pkg::cword_type      ct,
   output llcc_pkg::cword_type      st,
   output llcc_pkg::cword_type      cp,
   output llcc_pkg::cword_type      sp,
   output logic [4:0]               out_level
);

   localparam int N = llcc_pkg::CORDIC_STAGES;

   typedef struct packed {
      llcc_pkg::cword_type x;
      llcc_pkg::cword_type y;
      llcc_pkg::cword_type z;
      logic                flip;
   } rot_type;

   rot_type      a_ff [N+1];
   rot_type      b_ff [N+1];
   logic [4:0]   lv_ff [N+1];
   logic         v_ff [N+1];
   rot_type      a0;
   rot_type      b0;

   function automatic rot_type prep(input llcc_pkg::cword_type ang);
      rot_type r;
      r.x = llcc_pkg::CORDIC_START;
      r.y = '0;
      r.z = ang;
      r.flip = 1'b0;
      if (ang > llcc_pkg::Q30_ONE) begin
         r.z = ang - llcc_pkg::HALF_TURN;
         r.flip = 1'b1;
      end else if (ang < -llcc_pkg::Q30_ONE) begin
         r.z = ang + llcc_pkg::HALF_TURN;
         r.flip = 1'b1;
      end
      return r;
   endfunction

   function automatic rot_type step(input rot_type s, input int i);
      rot_type r;
      llcc_pkg::cword_type dx;
      llcc_pkg::cword_type dy;
      dx = s.y >>> i;
      dy = s.x >>> i;
      r = s;
      if (!s.z[35]) begin
         r.x = s.x - dx;
         r.y = s.y + dy;
         r.z = s.z - llcc_pkg::turn_angle(i);
      end else begin
         r.x = s.x + dx;
         r.y = s.y - dy;
         r.z = s.z + llcc_pkg::turn_angle(i);
      end
      return r;
   endfunction

   always_comb begin
      llcc_pkg::cword_type la;
      la = 36'(lat);
      if (la > llcc_pkg::Q30_ONE) la = llcc_pkg::Q30_ONE;
      if (la < -llcc_pkg::Q30_ONE) la = -llcc_pkg::Q30_ONE;
      a0 = prep(36'(lng));
      b0 = prep(la);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0]  <= a0;
         b_ff[0]  <= b0;
         lv_ff[0] <= level;
         for (int i = 0; i < N; i++) begin
            a_ff[i+1]  <= step(a_ff[i], i);
            b_ff[i+1]  <= step(b_ff[i], i);
            lv_ff[i+1] <= lv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < N; i++) v_ff[i+1] <= v_ff[i];
      end
   end

   assign out_valid = v_ff[N];
   assign ct = a_ff[N].flip ? -a_ff[N].x : a_ff[N].x;
   assign st = a_ff[N].flip ? -a_ff[N].y : a_ff[N].y;
   assign cp = b_ff[N].flip ? -b_ff[N].x : b_ff[N].x;
   assign sp = b_ff[N].flip ? -b_ff[N].y : b_ff[N].y;
   assign out_level = lv_ff[N];

endmodule

/* hw/rtl/llcc_project.sv */
// ----------------------------------------------------------------------------
// llcc_project
// Pipelined restoring divider (one quotient bit a stage) followed by a
// pipelined square root (one root bit a stage) and the level scaling.
// ----------------------------------------------------------------------------
module llcc_project (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  logic [31:0]  num_mag,
   input  logic [31:0]  den_mag,
   input  logic         neg,
   input  logic [4:0]   level,
   output logic         out_valid,
   output logic [29:0]  cell_index
);

   localparam int QB = 32;
   localparam int RB = 32;

   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] den;
      logic [31:0] q;
      logic        neg;
      logic [4:0]  level;
      logic        zero;
   } div_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] root;
      logic        neg;
      logic [4:0]  level;
   } sq_type;

   div_type d_ff [QB+1];
   sq_type  s_ff [RB+1];
   logic    dv_ff [QB+1];
   logic    sv_ff [RB+1];
   logic    o_valid_ff;
   logic [29:0] o_cell_ff;
   div_type d0;
   sq_type  s0;
   logic [29:0] cell_in;

   always_comb begin
      d0.rem   = {32'd0, num_mag};
      d0.den   = den_mag;
      d0.q     = '0;
      d0.neg   = neg;
      d0.level = level;
      d0.zero  = (den_mag == '0);
   end

   function automatic div_type dstep(input div_type s, input int i);
      div_type r;
      logic [63:0] t;
      r = s;
      t = {32'd0, s.den} << (QB - 1 - i);
      if (s.rem >= t && !s.zero) begin
         r.rem = s.rem - t;
         r.q[QB-1-i] = 1'b1;
      end
      return r;
   endfunction

   // The quotient of |n|*2^30/|d| is worked against num<<30.
   function automatic div_type dfix(input div_type s);
      div_type r;
      r = s;
      r.rem = {s.rem[33:0], 30'd0};
      return r;
   endfunction

   always_comb begin
      logic [31:0] umag;
      logic [63:0] w;
      umag = d_ff[QB].zero ? 32'd0 : d_ff[QB].q;
      w = 64'(32'h40000000) + 64'(umag) * 64'd3;
      s0.rem   = w << 30;
      s0.root  = '0;
      s0.neg   = d_ff[QB].neg && !d_ff[QB].zero && (umag != 0);
      s0.level = d_ff[QB].level;
   end

   function automatic sq_type sstep(input sq_type s, input int i);
      sq_type r;
      logic [63:0] trial;
      r = s;
      trial = ({32'd0, s.root} << (RB - i)) | (64'd1 << (2*(RB - 1 - i)));
      if (s.rem >= trial) begin
         r.rem = s.rem - trial;
         r.root[RB-1-i] = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      logic [32:0] sv;
      logic [32:0] idx;
      logic [4:0]  lv;
      logic [30:0] top;
      lv = (s_ff[RB].level > 5'(llcc_pkg::MAX_LEVEL)) ?
           5'(llcc_pkg::MAX_LEVEL) : s_ff[RB].level;
      sv = s_ff[RB].neg ? (33'h080000000 - {1'b0, s_ff[RB].root})
                        : {1'b0, s_ff[RB].root};
      idx = sv >> (5'd31 - lv);
      top = (31'd1 << lv) - 31'd1;
      cell_in = (idx > {2'd0, top}) ? top[29:0] : idx[29:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= dfix(d0);
         for (int i = 0; i < QB; i++) d_ff[i+1] <= dstep(d_ff[i], i);
         s_ff[0] <= s0;
         for (int i = 0; i < RB; i++) s_ff[i+1] <= sstep(s_ff[i], i);
         o_cell_ff <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QB; i++) dv_ff[i] <= 1'b0;
         for (int i = 0; i <= RB; i++) sv_ff[i] <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= in_valid;
         for (int i = 0; i < QB; i++) dv_ff[i+1] <= dv_ff[i];
         sv_ff[0] <= dv_ff[QB];
         for (int i = 0; i < RB; i++) sv_ff[i+1] <= sv_ff[i];
         o_valid_ff <= sv_ff[RB];
      end
   end

   assign out_valid = o_valid_ff;
   assign cell_index = o_cell_ff;

endmodule

/* hw/rtl/lat_lng_to_cube_cell_unit.sv */
// ----------------------------------------------------------------------------
// lat_lng_to_cube_cell_unit
// Maps a longitude/latitude point to cube face and cell indices.
// ----------------------------------------------------------------------------
// A point enters on the req_ channel as a transaction (tdata: longitude in
// bits 31:0, latitude in bits 63:32). One result leaves on the rsp_ channel
// per point (tdata: face 2:0, cell_i 32:3, cell_j 62:33, zero pad above).
// The csr_ port holds cell_level at address 0, reset value 30.
// Throughput is one point per cycle while rsp_tready does not stall it. A
// point passes the CORDIC stages, the products and face choice, the divider
// stages, the square root, the scaling and the output register.
// The whole pipeline advances only while the output register is free or
// being taken; when rsp_tvalid is high and rsp_tready low, every stage holds
// and nothing is lost. Reset clears all valid bits and sets the level to 30.
// ----------------------------------------------------------------------------
module lat_lng_to_cube_cell_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // longitude_angle, latitude_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // cube_face, cell_i, cell_j
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [0:0] ADDR_LEVEL = 1'b0;

   logic [4:0] level_ff;
   logic       adv;
   logic       cv;
   llcc_pkg::cword_type ct, st, cp, sp;
   logic [4:0] clv;

   logic signed [35:0] px_ff, py_ff, pz_ff;
   logic [4:0] lv1_ff;
   logic       v1_ff;
   logic [2:0] face_ff;
   logic [31:0] un_ff, vn_ff, dn_ff;
   logic       uneg_ff, vneg_ff;
   logic [4:0] lv2_ff;
   logic       v2_ff;
   logic [2:0] face_d_ff [67];
   logic       iv, jv;
   logic [29:0] ci, cj;

   assign csr_pready = 1'b1;
   assign csr_prdata = {27'd0, level_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 5'd30;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_LEVEL) begin
         level_ff <= csr_pwdata[4:0];
      end
   end

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   llcc_cordic u_cordic (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid),
      .lng(req_tdata[31:0]), .lat(req_tdata[63:32]), .level(level_ff),
      .out_valid(cv), .ct(ct), .st(st), .cp(cp), .sp(sp), .out_level(clv)
   );

   function automatic logic signed [35:0] mulq(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
      logic signed [71:0] p;
      p = 72'(a) * 72'(b) + 72'sd536870912;
      return 36'(p >>> 30);
   endfunction

   function automatic logic [31:0] amag(input logic signed [35:0] a);
      logic signed [35:0] m;
      m = a[35] ? -a : a;
      return m[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff  <= mulq(ct, cp);
         py_ff  <= mulq(st, cp);
         pz_ff  <= sp;
         lv1_ff <= clv;
      end
   end

   always_ff @(posedge clock) begin
      logic [31:0] ax, ay, az;
      logic [2:0]  f;
      logic signed [35:0] n1, n2, d;
      ax = amag(px_ff); ay = amag(py_ff); az = amag(pz_ff);
      if (ax > ay) f = (ax > az) ? 3'd0 : 3'd2;
      else         f = (ay > az) ? 3'd1 : 3'd2;
      case (f)
         3'd0: begin d = px_ff; n1 = py_ff; n2 = pz_ff; end
         3'd1: begin d = py_ff; n1 = -px_ff; n2 = pz_ff; end
         default: begin d = pz_ff; n1 = -px_ff; n2 = -py_ff; end
      endcase
      if (d[35]) begin
         case (f)
            3'd0: begin n1 = pz_ff; n2 = py_ff; end
            3'd1: begin n1 = pz_ff; n2 = -px_ff; end
            default: begin n1 = -py_ff; n2 = -px_ff; end
         endcase
         f = f + 3'd3;
      end
      if (adv) begin
         face_ff <= f;
         un_ff   <= amag(n1);
         vn_ff   <= amag(n2);
         dn_ff   <= amag(d);
         uneg_ff <= n1[35] ^ d[35];
         vneg_ff <= n2[35] ^ d[35];
         lv2_ff  <= lv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= cv;
         v2_ff <= v1_ff;
      end
   end

   llcc_project u_proj_i (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v2_ff),
      .num_mag(un_ff), .den_mag(dn_ff), .neg(uneg_ff), .level(lv2_ff),
      .out_valid(iv), .cell_index(ci)
   );

   llcc_project u_proj_j (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v2_ff),
      .num_mag(vn_ff), .den_mag(dn_ff), .neg(vneg_ff), .level(lv2_ff),
      .out_valid(jv), .cell_index(cj)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         face_d_ff[0] <= face_ff;
         for (int i = 0; i < 66; i++) face_d_ff[i+1] <= face_d_ff[i];
      end
   end

   assign rsp_tvalid = iv;
   assign rsp_tdata  = {1'b0, cj, ci, face_d_ff[66]};

`ifndef ASSERT_OFF
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset) iv == jv)
      else $error("cell lanes out of step");
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7))
      else $error("face code out of range");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && level_ff == 5'd0 |-> rsp_tdata[62:3] == '0)
      else $error("nonzero index at level zero");
`endif

endmodule
